// File: src/wrs_pkg.sv
// ----------------------------------------------------------------------------
// wrs_pkg
// Shared sizes, operation codes and field conversions for the weighted
// resampling block.
// ----------------------------------------------------------------------------
package wrs_pkg;

    localparam int MAX_PARTICLES = 1024;
    localparam int WEIGHT_BITS   = 32;
    localparam int POSE_BITS     = 16;

    localparam int IDX_W     = $clog2(MAX_PARTICLES);
    localparam int CNT_W     = $clog2(MAX_PARTICLES + 1);
    localparam int SUM_BITS  = WEIGHT_BITS + 10;
    localparam int FRAC_W    = 16;
    localparam int FIELD_W   = 16;
    localparam int INDEX_W   = 10;
    localparam int WEIGHT_IN = 32;
    localparam int POSE_ROW  = 3 * POSE_BITS;

    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_DRAW = 1'b1;

    function automatic logic [POSE_BITS-1:0] pose_in(input logic [FIELD_W-1:0] v);
        logic [FIELD_W+POSE_BITS-1:0] z;
        z = (FIELD_W + POSE_BITS)'(v);
        return z[POSE_BITS-1:0];
    endfunction

    function automatic logic [FIELD_W-1:0] pose_out(input logic [POSE_BITS-1:0] v);
        logic signed [FIELD_W+POSE_BITS-1:0] ext;
        ext = (FIELD_W + POSE_BITS)'(signed'(v));
        return ext[FIELD_W-1:0];
    endfunction

    function automatic logic [WEIGHT_BITS-1:0] weight_in(input logic [WEIGHT_IN-1:0] v);
        logic [WEIGHT_IN+WEIGHT_BITS-1:0] z;
        z = (WEIGHT_IN + WEIGHT_BITS)'(v);
        return z[WEIGHT_BITS-1:0];
    endfunction

    function automatic logic [INDEX_W-1:0] index_out(input logic [IDX_W-1:0] v);
        logic [INDEX_W+IDX_W-1:0] z;
        z = (INDEX_W + IDX_W)'(v);
        return z[INDEX_W-1:0];
    endfunction

endpackage

// File: src/wrs_ram.sv
// ----------------------------------------------------------------------------
// wrs_ram
// Generic simple dual-port RAM: one write port, one read port, registered
// read data.
// ----------------------------------------------------------------------------
module wrs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

// File: src/wrs_scale.sv
// ----------------------------------------------------------------------------
// wrs_scale
// Target = floor(total * fraction / 2^16), split into a high and a low
// partial product, then summed in a second stage.
// ----------------------------------------------------------------------------
module wrs_scale (
    input  logic                         clk,
    input  logic                         prod_en,
    input  logic                         sum_en,
    input  logic [wrs_pkg::SUM_BITS-1:0] total,
    input  logic [wrs_pkg::FRAC_W-1:0]   fraction,
    output logic [wrs_pkg::SUM_BITS-1:0] target
);

    localparam int HI_W = wrs_pkg::SUM_BITS - wrs_pkg::FRAC_W;
    localparam int LO_W = 2 * wrs_pkg::FRAC_W;

    logic [wrs_pkg::SUM_BITS-1:0] prod_hi_reg;
    logic [LO_W-1:0]              prod_lo_reg;
    logic [wrs_pkg::SUM_BITS-1:0] target_reg;
    logic [HI_W-1:0]              total_hi;
    logic [wrs_pkg::FRAC_W-1:0]   total_lo;

    assign total_hi = total[wrs_pkg::SUM_BITS-1:wrs_pkg::FRAC_W];
    assign total_lo = total[wrs_pkg::FRAC_W-1:0];

    always_ff @(posedge clk)
    begin
        if (prod_en)
        begin
            prod_hi_reg <= wrs_pkg::SUM_BITS'(total_hi) * wrs_pkg::SUM_BITS'(fraction);
            prod_lo_reg <= LO_W'(total_lo) * LO_W'(fraction);
        end
        if (sum_en)
        begin
            target_reg <= prod_hi_reg
                        + wrs_pkg::SUM_BITS'(prod_lo_reg[LO_W-1:wrs_pkg::FRAC_W]);
        end
    end

    assign target = target_reg;

endmodule

// File: src/weighted_resample_cdf_search.sv
// ----------------------------------------------------------------------------
// weighted_resample_cdf_search
// Multinomial resampling: loads build a cumulative weight table, draws scale
// a random fraction by the total and binary-search the table.
//
//   channel   handshake              word
//   item      item_valid/item_stall  operation, first_of_set, weight,
//                                    load_x, load_y, load_theta, random_fraction
//   result    result_valid/result_stall
//                                    drawn_x, drawn_y, drawn_theta,
//                                    drawn_index, draw_error
//
// Load: one write to each memory; a load into a full table writes nothing.
// Draw: accept, form the target, binary-search the table (one cumulative-memory
// read per step), read the pose. Error draws go from accept straight to the
// output state.
// No clearing pass after reset. A stalled result holds the next draw in its
// final state; until then loads are still taken while a result waits.
// ----------------------------------------------------------------------------
module weighted_resample_cdf_search (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        item_valid,
    output logic        item_stall,
    input  logic        operation,
    input  logic        first_of_set,
    input  logic [31:0] weight,
    input  logic [15:0] load_x,
    input  logic [15:0] load_y,
    input  logic [15:0] load_theta,
    input  logic [15:0] random_fraction,
    output logic        result_valid,
    input  logic        result_stall,
    output logic [15:0] drawn_x,
    output logic [15:0] drawn_y,
    output logic [15:0] drawn_theta,
    output logic [9:0]  drawn_index,
    output logic        draw_error
);

    localparam int IDX_W = wrs_pkg::IDX_W;
    localparam int CNT_W = wrs_pkg::CNT_W;
    localparam int SUM_W = wrs_pkg::SUM_BITS;
    localparam int PB    = wrs_pkg::POSE_BITS;

    typedef enum logic [3:0] {
        S_IDLE   = 4'b0001,
        S_TGT    = 4'b0010,
        S_SEARCH = 4'b0100,
        S_OUT    = 4'b1000
    } state_t;

    state_t             state_reg, state_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic [SUM_W-1:0]   total_reg, total_next;
    logic [IDX_W-1:0]   lo_reg, lo_next;
    logic [IDX_W-1:0]   hi_reg, hi_next;
    logic [IDX_W-1:0]   mid_reg, mid_next;
    logic               err_reg, err_next;
    logic               result_valid_reg;
    logic [15:0]        drawn_x_reg, drawn_y_reg, drawn_theta_reg;
    logic [9:0]         drawn_index_reg;
    logic               draw_error_reg;

    logic               item_accept;
    logic               out_free;
    logic [CNT_W-1:0]   base_count;
    logic [SUM_W-1:0]   base_total;
    logic [SUM_W:0]     sum_wide;
    logic [SUM_W-1:0]   sum_sat;
    logic [CNT_W-1:0]   last_cnt;
    logic [IDX_W-1:0]   lo_n, hi_n, mid_n;
    logic               cum_gt;
    logic               wr_en;
    logic [IDX_W-1:0]   cum_rd_addr;
    logic [IDX_W-1:0]   pose_rd_addr;
    logic [SUM_W-1:0]   cum_q;
    logic [3*PB-1:0]    pose_q;
    logic [3*PB-1:0]    pose_wr;
    logic [SUM_W-1:0]   target;

    assign item_accept = item_valid && !item_stall;
    assign item_stall  = (state_reg != S_IDLE);
    assign out_free    = !result_valid_reg || !result_stall;

    assign base_count = first_of_set ? '0 : count_reg;
    assign base_total = first_of_set ? '0 : total_reg;
    assign sum_wide   = {1'b0, base_total} + (SUM_W + 1)'(wrs_pkg::weight_in(weight));
    assign sum_sat    = sum_wide[SUM_W] ? '1 : sum_wide[SUM_W-1:0];
    assign last_cnt   = count_reg - CNT_W'(1);

    assign cum_gt = cum_q > target;
    assign lo_n   = cum_gt ? lo_reg : mid_reg + IDX_W'(1);
    assign hi_n   = cum_gt ? mid_reg : hi_reg;
    assign mid_n  = lo_n + ((hi_n - lo_n) >> 1);

    assign pose_wr = {wrs_pkg::pose_in(load_theta), wrs_pkg::pose_in(load_y),
                      wrs_pkg::pose_in(load_x)};
    assign pose_rd_addr = (state_reg == S_SEARCH) ? lo_n : lo_reg;

    always_comb
    begin
        state_next  = state_reg;
        count_next  = count_reg;
        total_next  = total_reg;
        lo_next     = lo_reg;
        hi_next     = hi_reg;
        mid_next    = mid_reg;
        err_next    = err_reg;
        cum_rd_addr = mid_reg;
        wr_en       = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (item_accept)
                begin
                    if (operation == wrs_pkg::OP_LOAD)
                    begin
                        count_next = base_count;
                        total_next = base_total;
                        if (base_count < CNT_W'(wrs_pkg::MAX_PARTICLES))
                        begin
                            wr_en      = 1'b1;
                            count_next = base_count + CNT_W'(1);
                            total_next = sum_sat;
                        end
                    end
                    else
                    begin
                        lo_next = '0;
                        hi_next = last_cnt[IDX_W-1:0];
                        if (count_reg == '0 || total_reg == '0)
                        begin
                            err_next   = 1'b1;
                            state_next = S_OUT;
                        end
                        else
                        begin
                            err_next   = 1'b0;
                            state_next = S_TGT;
                        end
                    end
                end
            end
            S_TGT:
            begin
                cum_rd_addr = hi_reg >> 1;
                mid_next    = hi_reg >> 1;
                state_next  = (hi_reg == '0) ? S_OUT : S_SEARCH;
            end
            S_SEARCH:
            begin
                lo_next = lo_n;
                if (lo_n < hi_n)
                begin
                    cum_rd_addr = mid_n;
                    mid_next    = mid_n;
                    hi_next     = hi_n;
                end
                else
                begin
                    state_next = S_OUT;
                end
            end
            S_OUT:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            count_reg        <= '0;
            total_reg        <= '0;
            lo_reg           <= '0;
            hi_reg           <= '0;
            mid_reg          <= '0;
            err_reg          <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            total_reg <= total_next;
            lo_reg    <= lo_next;
            hi_reg    <= hi_next;
            mid_reg   <= mid_next;
            err_reg   <= err_next;
            if (state_reg == S_OUT && out_free)
            begin
                result_valid_reg <= 1'b1;
            end
            else if (!result_stall)
            begin
                result_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == S_OUT && out_free)
        begin
            draw_error_reg <= err_reg;
            if (err_reg)
            begin
                drawn_x_reg     <= '0;
                drawn_y_reg     <= '0;
                drawn_theta_reg <= '0;
                drawn_index_reg <= '0;
            end
            else
            begin
                drawn_x_reg     <= wrs_pkg::pose_out(pose_q[PB-1:0]);
                drawn_y_reg     <= wrs_pkg::pose_out(pose_q[2*PB-1:PB]);
                drawn_theta_reg <= wrs_pkg::pose_out(pose_q[3*PB-1:2*PB]);
                drawn_index_reg <= wrs_pkg::index_out(lo_reg);
            end
        end
    end

    wrs_ram #(
        .WIDTH (SUM_W),
        .DEPTH (wrs_pkg::MAX_PARTICLES)
    ) u_cum_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (base_count[IDX_W-1:0]),
        .wr_data (sum_sat),
        .rd_addr (cum_rd_addr),
        .rd_data (cum_q)
    );

    wrs_ram #(
        .WIDTH (wrs_pkg::POSE_ROW),
        .DEPTH (wrs_pkg::MAX_PARTICLES)
    ) u_pose_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (base_count[IDX_W-1:0]),
        .wr_data (pose_wr),
        .rd_addr (pose_rd_addr),
        .rd_data (pose_q)
    );

    wrs_scale u_scale (
        .clk      (clk),
        .prod_en  (item_accept),
        .sum_en   (state_reg == S_TGT),
        .total    (total_reg),
        .fraction (random_fraction),
        .target   (target)
    );

    assign result_valid = result_valid_reg;
    assign drawn_x      = drawn_x_reg;
    assign drawn_y      = drawn_y_reg;
    assign drawn_theta  = drawn_theta_reg;
    assign drawn_index  = drawn_index_reg;
    assign draw_error   = draw_error_reg;

`ifndef SYNTHESIS
    a_search_window: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SEARCH) |-> (mid_reg >= lo_reg && mid_reg < hi_reg))
        else $error("search midpoint outside window");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(wrs_pkg::MAX_PARTICLES))
        else $error("particle count past table depth");

    a_busy_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_IDLE && !err_reg) |-> (total_reg != '0 && count_reg != '0))
        else $error("search started on empty set");

    a_error_word: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && draw_error) |-> (drawn_index == '0 && drawn_x == '0))
        else $error("error word carries a pose");
`endif

endmodule

// File: bench/weighted_resample_cdf_search_test.sv
// ----------------------------------------------------------------------------
// weighted_resample_cdf_search_test
// Drives load and draw words into the resampler and compares every draw
// result with an in-bench model of the cumulative table and its search.
// A short directed table goes first, then random particle sets of varied
// size and weight spread, one set that fills the table past its end, and
// some noise. The sender idles in bursts; the receiver stalls in phases.
// ----------------------------------------------------------------------------
module weighted_resample_cdf_search_test;

    localparam int CYCLE_LIMIT  = 1000000;
    localparam int RANDOM_WORDS = 1800;

    typedef struct packed {
        logic        op;
        logic        first;
        logic [31:0] weight;
        logic [15:0] x;
        logic [15:0] y;
        logic [15:0] th;
        logic [15:0] frac;
    } word_t;

    typedef struct packed {
        logic [15:0]                x;
        logic [15:0]                y;
        logic [15:0]                th;
        logic [wrs_pkg::INDEX_W-1:0] index;
        logic                       err;
    } draw_t;

    typedef struct packed {
        word_t w;
        bit    typed;
        draw_t exp;
    } row_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        item_valid = 1'b0;
    logic        item_stall;
    logic        operation = wrs_pkg::OP_LOAD;
    logic        first_of_set = 1'b0;
    logic [31:0] weight = '0;
    logic [15:0] load_x = '0;
    logic [15:0] load_y = '0;
    logic [15:0] load_theta = '0;
    logic [15:0] random_fraction = '0;
    logic        result_valid;
    logic        result_stall = 1'b0;
    logic [15:0] drawn_x;
    logic [15:0] drawn_y;
    logic [15:0] drawn_theta;
    logic [9:0]  drawn_index;
    logic        draw_error;

    // model state
    logic [wrs_pkg::SUM_BITS-1:0] cum_table [wrs_pkg::MAX_PARTICLES];
    logic [47:0]                  pose_table [wrs_pkg::MAX_PARTICLES];
    int                           table_count = 0;
    logic [wrs_pkg::SUM_BITS-1:0] set_total = '0;

    draw_t pending_draws [$];
    row_t  directed_rows [$];
    int    mismatch_count = 0;
    int    cycle_count = 0;
    int    burst_left = 0;
    int    stall_phase_left = 0;
    int    stall_mode = 0;

    weighted_resample_cdf_search DUT (
        .clk             (clk),
        .rst_n           (rst_n),
        .item_valid      (item_valid),
        .item_stall      (item_stall),
        .operation       (operation),
        .first_of_set    (first_of_set),
        .weight          (weight),
        .load_x          (load_x),
        .load_y          (load_y),
        .load_theta      (load_theta),
        .random_fraction (random_fraction),
        .result_valid    (result_valid),
        .result_stall    (result_stall),
        .drawn_x         (drawn_x),
        .drawn_y         (drawn_y),
        .drawn_theta     (drawn_theta),
        .drawn_index     (drawn_index),
        .draw_error      (draw_error)
    );

    always #6 clk = ~clk;

    // returns 1 when the word yields a draw result
    function automatic bit predict_resample(input word_t w, output draw_t r);
        logic [wrs_pkg::SUM_BITS:0] acc;
        logic [63:0]                target;
        int                         lo;
        int                         hi;
        int                         mid;
        r = '0;
        if (w.op == wrs_pkg::OP_LOAD)
        begin
            if (w.first)
            begin
                table_count = 0;
                set_total   = '0;
            end
            if (table_count < wrs_pkg::MAX_PARTICLES)
            begin
                acc = {1'b0, set_total} + (wrs_pkg::SUM_BITS + 1)'(w.weight);
                if (acc[wrs_pkg::SUM_BITS])
                    set_total = '1;
                else
                    set_total = acc[wrs_pkg::SUM_BITS-1:0];
                cum_table[table_count]  = set_total;
                pose_table[table_count] = {w.x, w.y, w.th};
                table_count++;
            end
            return 1'b0;
        end
        if (table_count == 0 || set_total == '0)
        begin
            r.err = 1'b1;
            return 1'b1;
        end
        target = 64'(set_total >> 16) * 64'(w.frac)
               + ((64'(set_total[15:0]) * 64'(w.frac)) >> 16);
        lo = 0;
        hi = table_count - 1;
        while (lo < hi)
        begin
            mid = lo + (hi - lo) / 2;
            if (64'(cum_table[mid]) > target)
                hi = mid;
            else
                lo = mid + 1;
        end
        {r.x, r.y, r.th} = pose_table[lo];
        r.index = wrs_pkg::INDEX_W'(lo);
        return 1'b1;
    endfunction

    function automatic word_t random_word();
        word_t w;
        w.op     = 1'($urandom_range(0, 1));
        w.first  = ($urandom_range(0, 7) == 0);
        w.weight = 32'($urandom);
        w.x      = 16'($urandom);
        w.y      = 16'($urandom);
        w.th     = 16'($urandom);
        w.frac   = 16'($urandom);
        return w;
    endfunction

    function automatic logic [31:0] pick_weight(input int mode);
        case (mode)
            0: return 32'($urandom);
            1: return 32'($urandom_range(0, 3));
            2: return ($urandom_range(0, 2) == 0) ? 32'd0 : 32'($urandom);
            3: return {8'($urandom), 24'h0};
            default: return 32'd0;
        endcase
    endfunction

    function automatic logic [15:0] pick_fraction();
        case ($urandom_range(0, 9))
            0: return 16'h0000;
            1: return 16'hFFFF;
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic add_row(input logic op, input logic first, input logic [31:0] wt,
                           input logic [15:0] x, input logic [15:0] y,
                           input logic [15:0] th, input logic [15:0] frac,
                           input bit typed, input logic [15:0] ex,
                           input logic [15:0] ey, input logic [15:0] eth,
                           input logic [9:0] eidx, input logic eerr);
        row_t r;
        r.w     = '{op, first, wt, x, y, th, frac};
        r.typed = typed;
        r.exp   = '{ex, ey, eth, eidx, eerr};
        directed_rows.push_back(r);
    endtask

    task automatic send_word(input word_t w, input bit typed, input draw_t typed_result);
        int    gap;
        draw_t r;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0)
            begin
                item_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 24);
        end
        item_valid      <= 1'b1;
        operation       <= w.op;
        first_of_set    <= w.first;
        weight          <= w.weight;
        load_x          <= w.x;
        load_y          <= w.y;
        load_theta      <= w.th;
        random_fraction <= w.frac;
        @(posedge clk);
        while (item_stall)
            @(posedge clk);
        burst_left--;
        if (predict_resample(w, r))
            pending_draws.push_back(typed ? typed_result : r);
    endtask

    task automatic send_load(input logic first, input logic [31:0] wt);
        word_t w;
        w        = random_word();
        w.op     = wrs_pkg::OP_LOAD;
        w.first  = first;
        w.weight = wt;
        send_word(w, 1'b0, '0);
    endtask

    task automatic send_draw(input logic [15:0] frac, input logic first);
        word_t w;
        w       = random_word();
        w.op    = wrs_pkg::OP_DRAW;
        w.first = first;
        w.frac  = frac;
        send_word(w, 1'b0, '0);
    endtask

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (stall_phase_left == 0)
            begin
                stall_mode       = $urandom_range(0, 2);
                stall_phase_left = $urandom_range(8, 60);
            end
            stall_phase_left--;
            case (stall_mode)
                0: result_stall <= 1'b0;
                1: result_stall <= 1'($urandom_range(0, 1));
                default: result_stall <= ($urandom_range(0, 3) != 0);
            endcase
        end
    end

    always @(posedge clk)
    begin
        draw_t got;
        draw_t want;
        cycle_count++;
        got = '{drawn_x, drawn_y, drawn_theta, drawn_index, draw_error};
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycle_count);
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
        else if (rst_n && result_valid && !result_stall)
        begin
            if (pending_draws.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("unexpected draw: x=%h y=%h theta=%h index=%0d error=%b",
                             got.x, got.y, got.th, got.index, got.err);
            end
            else
            begin
                want = pending_draws.pop_front();
                if (got !== want)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                    begin
                        $display("draw mismatch: expected x=%h y=%h theta=%h index=%0d error=%b",
                                 want.x, want.y, want.th, want.index, want.err);
                        $display("               got      x=%h y=%h theta=%h index=%0d error=%b",
                                 got.x, got.y, got.th, got.index, got.err);
                    end
                end
            end
        end
    end

    initial
    begin
        int  n;
        int  k;
        int  i;
        int  wmode;
        int  random_count;
        bit  filled;
        random_count = 0;
        filled       = 1'b0;

        //      op                first  weight        x         y         theta     frac
        add_row(wrs_pkg::OP_DRAW, 1'b0, 32'h0,        16'h0,    16'h0,    16'h0,    16'h1234,
                1'b1, 16'h0, 16'h0, 16'h0, 10'd0, 1'b1);
        add_row(wrs_pkg::OP_DRAW, 1'b1, 32'hFFFFFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                1'b1, 16'h0, 16'h0, 16'h0, 10'd0, 1'b1);
        add_row(wrs_pkg::OP_LOAD, 1'b1, 32'h0,        16'h8000, 16'h7FFF, 16'h0000, 16'h0,
                1'b0, 16'h0, 16'h0, 16'h0, 10'd0, 1'b0);
        add_row(wrs_pkg::OP_DRAW, 1'b0, 32'h0,        16'h0,    16'h0,    16'h0,    16'h0000,
                1'b1, 16'h0, 16'h0, 16'h0, 10'd0, 1'b1);
        add_row(wrs_pkg::OP_DRAW, 1'b0, 32'h0,        16'h0,    16'h0,    16'h0,    16'hFFFF,
                1'b1, 16'h0, 16'h0, 16'h0, 10'd0, 1'b1);
        add_row(wrs_pkg::OP_LOAD, 1'b0, 32'hFFFFFFFF, 16'h7FFF, 16'h8000, 16'hFFFF, 16'h0,
                1'b0, 16'h0, 16'h0, 16'h0, 10'd0, 1'b0);
        add_row(wrs_pkg::OP_DRAW, 1'b0, 32'h0,        16'h0,    16'h0,    16'h0,    16'h0000,
                1'b1, 16'h7FFF, 16'h8000, 16'hFFFF, 10'd1, 1'b0);
        add_row(wrs_pkg::OP_DRAW, 1'b0, 32'h0,        16'h0,    16'h0,    16'h0,    16'hFFFF,
                1'b1, 16'h7FFF, 16'h8000, 16'hFFFF, 10'd1, 1'b0);
        add_row(wrs_pkg::OP_LOAD, 1'b1, 32'h1,        16'h0001, 16'h0002, 16'h0003, 16'h0,
                1'b0, 16'h0, 16'h0, 16'h0, 10'd0, 1'b0);
        add_row(wrs_pkg::OP_DRAW, 1'b0, 32'h0,        16'h0,    16'h0,    16'h0,    16'hFFFF,
                1'b1, 16'h0001, 16'h0002, 16'h0003, 10'd0, 1'b0);
        add_row(wrs_pkg::OP_LOAD, 1'b0, 32'h1,        16'h0004, 16'h0005, 16'h0006, 16'h0,
                1'b0, 16'h0, 16'h0, 16'h0, 10'd0, 1'b0);
        add_row(wrs_pkg::OP_DRAW, 1'b0, 32'h0,        16'h0,    16'h0,    16'h0,    16'h8000,
                1'b1, 16'h0004, 16'h0005, 16'h0006, 10'd1, 1'b0);
        add_row(wrs_pkg::OP_DRAW, 1'b0, 32'h0,        16'h0,    16'h0,    16'h0,    16'h7FFF,
                1'b1, 16'h0001, 16'h0002, 16'h0003, 10'd0, 1'b0);
        add_row(wrs_pkg::OP_LOAD, 1'b1, 32'h00010000, 16'h1111, 16'hAAAA, 16'h5555, 16'h0,
                1'b0, 16'h0, 16'h0, 16'h0, 10'd0, 1'b0);
        add_row(wrs_pkg::OP_LOAD, 1'b0, 32'h0,        16'hEEEE, 16'h5555, 16'hAAAA, 16'h0,
                1'b0, 16'h0, 16'h0, 16'h0, 10'd0, 1'b0);
        add_row(wrs_pkg::OP_LOAD, 1'b0, 32'h80000000, 16'h8001, 16'h7FFE, 16'h1234, 16'h0,
                1'b0, 16'h0, 16'h0, 16'h0, 10'd0, 1'b0);
        add_row(wrs_pkg::OP_LOAD, 1'b0, 32'h0000FFFF, 16'hC000, 16'h3FFF, 16'hFEDC, 16'h0,
                1'b0, 16'h0, 16'h0, 16'h0, 10'd0, 1'b0);
        add_row(wrs_pkg::OP_DRAW, 1'b0, 32'h0,        16'h0,    16'h0,    16'h0,    16'h0000,
                1'b0, 16'h0, 16'h0, 16'h0, 10'd0, 1'b0);
        add_row(wrs_pkg::OP_DRAW, 1'b0, 32'h0,        16'h0,    16'h0,    16'h0,    16'h8000,
                1'b0, 16'h0, 16'h0, 16'h0, 10'd0, 1'b0);
        add_row(wrs_pkg::OP_DRAW, 1'b0, 32'h0,        16'h0,    16'h0,    16'h0,    16'hFFFF,
                1'b0, 16'h0, 16'h0, 16'h0, 10'd0, 1'b0);
        add_row(wrs_pkg::OP_DRAW, 1'b1, 32'h0,        16'h0,    16'h0,    16'h0,    16'h0001,
                1'b0, 16'h0, 16'h0, 16'h0, 10'd0, 1'b0);
        add_row(wrs_pkg::OP_LOAD, 1'b1, 32'h7FFFFFFF, 16'h0F0F, 16'hF0F0, 16'h00FF, 16'h0,
                1'b0, 16'h0, 16'h0, 16'h0, 10'd0, 1'b0);
        add_row(wrs_pkg::OP_DRAW, 1'b0, 32'h0,        16'h0,    16'h0,    16'h0,    16'hFFFF,
                1'b0, 16'h0, 16'h0, 16'h0, 10'd0, 1'b0);

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        foreach (directed_rows[j])
            send_word(directed_rows[j].w, directed_rows[j].typed, directed_rows[j].exp);

        while (random_count < RANDOM_WORDS)
        begin
            // one set runs past the end of the table, then draws across it
            if (!filled && random_count >= 600)
            begin
                filled = 1'b1;
                for (i = 0; i < wrs_pkg::MAX_PARTICLES + 3; i++)
                    send_load(i == 0, ($urandom_range(0, 15) == 0) ? 32'd0 : 32'($urandom));
                for (i = 0; i < 8; i++)
                    send_draw(pick_fraction(), 1'b0);
                random_count += wrs_pkg::MAX_PARTICLES + 3 + 8;
            end
            case ($urandom_range(0, 9))
                0:
                begin
                    n = $urandom_range(1, 6);
                    for (i = 0; i < n; i++)
                        send_word(random_word(), 1'b0, '0);
                    random_count += n;
                end
                1:
                begin
                    n = $urandom_range(1, 4);
                    for (i = 0; i < n; i++)
                        send_draw(pick_fraction(), 1'($urandom_range(0, 1)));
                    random_count += n;
                end
                default:
                begin
                    wmode = $urandom_range(0, 4);
                    n = ($urandom_range(0, 9) == 0) ? $urandom_range(17, 120)
                                                    : $urandom_range(1, 16);
                    for (i = 0; i < n; i++)
                        send_load(i == 0, pick_weight(wmode));
                    k = $urandom_range(1, 6);
                    for (i = 0; i < k; i++)
                        send_draw(pick_fraction(), ($urandom_range(0, 7) == 0));
                    random_count += n + k;
                end
            endcase
        end
        item_valid <= 1'b0;

        while (pending_draws.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);

        if (mismatch_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
